/* rtl/core/ordered_array_list_engine_unit_assert.svh */
// Assertion macros for the ordered array list engine.
// Expect clk and rst_n in the scope of use; empty when SYNTH is defined.
`ifndef ORDERED_ARRAY_LIST_ENGINE_UNIT_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define OALE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define OALE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define OALE_ASSERT_SAME(lbl, ante, cons, msg)
`define OALE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/core/oale_pkg.sv */
// Shared types and constants of the ordered array list engine.
// No dependencies.
`timescale 1ns / 1ps
package oale_pkg;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 6;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 6;

  localparam int DEF_CAPACITY = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_DELETE  = 3'd1,
    CMD_SORTED  = 3'd2,
    CMD_REVERSE = 3'd3,
    CMD_READ    = 3'd4,
    CMD_CLEAR   = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BADPOS = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT_UP,
    ST_SHIFT_DN,
    ST_PUT,
    ST_REV_RD,
    ST_REV_LO,
    ST_REV_HI,
    ST_RD_CAP,
    ST_EMIT
  } state_t;

endpackage

/* rtl/core/oale_ram.sv */
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps
module oale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* rtl/core/ordered_array_list_engine_unit.sv */
// Ordered array list engine: packed list of signed values in one RAM.
// Depends on oale_pkg, oale_ram and ordered_array_list_engine_unit_assert.svh.
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  in      | in_valid/in_ready, cmd, position, value | to block
//  out     | out_valid/out_ready, status, read_value,| from block
//          | count                                  |
//
// One item at a time; each element move uses the single write port.
// Insert shifts the tail up one element at a time, then writes the value; sorted insert
//   first searches for the first element >= value; delete shifts the tail down; reverse
//   swaps pairs from both ends; read captures one element; the rest go to the result.
// Reset clears length and control state only; the RAM holds no reset value.
// A waiting result holds in the load state until the output register frees.
`timescale 1ns / 1ps
`include "ordered_array_list_engine_unit_assert.svh"
module ordered_array_list_engine_unit #(
  parameter int CAPACITY = oale_pkg::DEF_CAPACITY
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [oale_pkg::CMD_W-1:0]           in_cmd,
  input  logic [oale_pkg::POS_W-1:0]           in_position,
  input  logic signed [oale_pkg::VAL_W-1:0]    in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [oale_pkg::STAT_W-1:0]          out_status,
  output logic signed [oale_pkg::VAL_W-1:0]    out_read_value,
  output logic [oale_pkg::CNT_W-1:0]           out_count
);

  localparam int CW = oale_pkg::CNT_W;
  localparam int VW = oale_pkg::VAL_W;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP_L = CW'(CAPACITY);

  // control and list state
  oale_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]     len_r, len_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;    // RAM read pointer
  logic [CW-1:0]     slot_r, slot_nxt;  // where the new value lands
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [VW-1:0]     val_r, val_nxt;
  logic [VW-1:0]     tmp_r, tmp_nxt;    // low element of a swap pair
  logic              wpend_r, wpend_nxt; // write read data back next cycle
  logic [CW-1:0]     wa_r, wa_nxt;

  // result waiting for the output register
  oale_pkg::status_t res_status_r, res_status_nxt;
  logic [VW-1:0]     res_rd_r, res_rd_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [oale_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [VW-1:0]     out_rd_r, out_rd_nxt;
  logic [CW-1:0]     out_count_r, out_count_nxt;

  // RAM ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [VW-1:0]     ram_wdata, rd_a, rd_b;

  // command decode, used while idle
  oale_pkg::cmd_t    cmd;
  logic              accept;
  logic              is_full;
  logic              ins_bad;   // insert position outside 1..len+1
  logic              acc_bad;   // delete/read position outside 1..len
  logic [CW-1:0]     slot_in;
  logic              found_ge;  // search hit: element >= value
  logic              load_out;

  assign cmd      = oale_pkg::cmd_t'(in_cmd);
  assign in_ready = (state_r == oale_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_full  = (len_r >= CAP_L);
  assign ins_bad  = (in_position == '0) ||
                    ({1'b0, in_position} > ({1'b0, len_r} + (CW+1)'(1)));
  assign acc_bad  = (in_position == '0) || (in_position > len_r);
  assign slot_in  = in_position - CW'(1);
  assign found_ge = ($signed(rd_a) >= $signed(val_r));
  assign load_out = (state_r == oale_pkg::ST_EMIT) && (!out_valid_r || out_ready);

  oale_ram #(
    .WIDTH (VW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (rd_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (rd_b)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      oale_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            oale_pkg::CMD_INSERT: begin
              if (is_full || ins_bad) state_nxt = oale_pkg::ST_EMIT;
              else if (slot_in == len_r) state_nxt = oale_pkg::ST_PUT;
              else state_nxt = oale_pkg::ST_SHIFT_UP;
            end
            oale_pkg::CMD_DELETE: begin
              if (acc_bad || in_position == len_r) state_nxt = oale_pkg::ST_EMIT;
              else state_nxt = oale_pkg::ST_SHIFT_DN;
            end
            oale_pkg::CMD_SORTED: begin
              if (is_full) state_nxt = oale_pkg::ST_EMIT;
              else if (len_r == '0) state_nxt = oale_pkg::ST_PUT;
              else state_nxt = oale_pkg::ST_SEARCH;
            end
            oale_pkg::CMD_REVERSE: begin
              if (len_r < CW'(2)) state_nxt = oale_pkg::ST_EMIT;
              else state_nxt = oale_pkg::ST_REV_RD;
            end
            oale_pkg::CMD_READ: begin
              if (acc_bad) state_nxt = oale_pkg::ST_EMIT;
              else state_nxt = oale_pkg::ST_RD_CAP;
            end
            default: state_nxt = oale_pkg::ST_EMIT;
          endcase
        end
      end
      oale_pkg::ST_SEARCH: begin
        if (found_ge) state_nxt = oale_pkg::ST_SHIFT_UP;
        else if (ptr_r + CW'(1) == len_r) state_nxt = oale_pkg::ST_PUT;
      end
      oale_pkg::ST_SHIFT_UP: begin
        if (ptr_r == slot_r) state_nxt = oale_pkg::ST_PUT;
      end
      oale_pkg::ST_SHIFT_DN: begin
        if (ptr_r == len_r - CW'(1)) state_nxt = oale_pkg::ST_EMIT;
      end
      oale_pkg::ST_PUT: begin
        if (!wpend_r) state_nxt = oale_pkg::ST_EMIT;
      end
      oale_pkg::ST_REV_RD: state_nxt = oale_pkg::ST_REV_LO;
      oale_pkg::ST_REV_LO: state_nxt = oale_pkg::ST_REV_HI;
      oale_pkg::ST_REV_HI: begin
        if ((lo_r + CW'(1)) < (hi_r - CW'(1))) state_nxt = oale_pkg::ST_REV_LO;
        else state_nxt = oale_pkg::ST_EMIT;
      end
      oale_pkg::ST_RD_CAP: state_nxt = oale_pkg::ST_EMIT;
      oale_pkg::ST_EMIT: begin
        if (load_out) state_nxt = oale_pkg::ST_IDLE;
      end
      default: state_nxt = oale_pkg::ST_IDLE;
    endcase
  end

  // datapath, RAM control and output register
  always_comb begin
    len_nxt        = len_r;
    ptr_nxt        = ptr_r;
    slot_nxt       = slot_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    val_nxt        = val_r;
    tmp_nxt        = tmp_r;
    wpend_nxt      = 1'b0;
    wa_nxt         = wa_r;
    res_status_nxt = res_status_r;
    res_rd_nxt     = res_rd_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_rd_nxt     = out_rd_r;
    out_count_nxt  = out_count_r;
    ram_raddr_a    = ptr_r[AW-1:0];
    ram_raddr_b    = hi_r[AW-1:0];
    ram_we         = 1'b0;
    ram_waddr      = wa_r[AW-1:0];
    ram_wdata      = rd_a;

    // a pending shift write always goes first
    if (wpend_r) begin
      ram_we = 1'b1;
    end

    case (state_r)
      oale_pkg::ST_IDLE: begin
        ram_raddr_a = (cmd == oale_pkg::CMD_SORTED) ? '0 : slot_in[AW-1:0];
        if (accept) begin
          res_status_nxt = oale_pkg::STAT_OK;
          res_rd_nxt     = '0;
          val_nxt        = in_value;
          lo_nxt         = '0;
          hi_nxt         = len_r - CW'(1);
          case (cmd)
            oale_pkg::CMD_INSERT: begin
              slot_nxt = slot_in;
              ptr_nxt  = len_r - CW'(1);
              if (is_full) res_status_nxt = oale_pkg::STAT_FULL;
              else if (ins_bad) res_status_nxt = oale_pkg::STAT_BADPOS;
            end
            oale_pkg::CMD_DELETE: begin
              ptr_nxt = in_position;
              if (acc_bad) res_status_nxt = oale_pkg::STAT_BADPOS;
              else if (in_position == len_r) len_nxt = len_r - CW'(1);
            end
            oale_pkg::CMD_SORTED: begin
              slot_nxt = '0;
              ptr_nxt  = '0;
              if (is_full) res_status_nxt = oale_pkg::STAT_FULL;
            end
            oale_pkg::CMD_READ: begin
              if (acc_bad) res_status_nxt = oale_pkg::STAT_BADPOS;
            end
            oale_pkg::CMD_CLEAR: len_nxt = '0;
            default: ;
          endcase
        end
      end
      oale_pkg::ST_SEARCH: begin
        // rd_a holds element ptr_r; fetch the next one meanwhile
        ram_raddr_a = AW'(ptr_r + CW'(1));
        if (found_ge) begin
          slot_nxt = ptr_r;
          ptr_nxt  = len_r - CW'(1);
        end else if (ptr_r + CW'(1) == len_r) begin
          slot_nxt = len_r;
        end else begin
          ptr_nxt = ptr_r + CW'(1);
        end
      end
      oale_pkg::ST_SHIFT_UP: begin
        wpend_nxt = 1'b1;
        wa_nxt    = ptr_r + CW'(1);
        if (ptr_r != slot_r) ptr_nxt = ptr_r - CW'(1);
      end
      oale_pkg::ST_SHIFT_DN: begin
        wpend_nxt = 1'b1;
        wa_nxt    = ptr_r - CW'(1);
        if (ptr_r == len_r - CW'(1)) len_nxt = len_r - CW'(1);
        else ptr_nxt = ptr_r + CW'(1);
      end
      oale_pkg::ST_PUT: begin
        if (!wpend_r) begin
          ram_we    = 1'b1;
          ram_waddr = slot_r[AW-1:0];
          ram_wdata = val_r;
          len_nxt   = len_r + CW'(1);
        end
      end
      oale_pkg::ST_REV_RD: begin
        ram_raddr_a = lo_r[AW-1:0];
        ram_raddr_b = hi_r[AW-1:0];
      end
      oale_pkg::ST_REV_LO: begin
        ram_we    = 1'b1;
        ram_waddr = lo_r[AW-1:0];
        ram_wdata = rd_b;
        tmp_nxt   = rd_a;
      end
      oale_pkg::ST_REV_HI: begin
        ram_we      = 1'b1;
        ram_waddr   = hi_r[AW-1:0];
        ram_wdata   = tmp_r;
        ram_raddr_a = AW'(lo_r + CW'(1));
        ram_raddr_b = AW'(hi_r - CW'(1));
        lo_nxt      = lo_r + CW'(1);
        hi_nxt      = hi_r - CW'(1);
      end
      oale_pkg::ST_RD_CAP: res_rd_nxt = rd_a;
      oale_pkg::ST_EMIT: begin
        if (load_out) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_rd_nxt     = res_rd_r;
          out_count_nxt  = len_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oale_pkg::ST_IDLE;
      len_r       <= '0;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      wpend_r     <= wpend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    slot_r       <= slot_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    val_r        <= val_nxt;
    tmp_r        <= tmp_nxt;
    wa_r         <= wa_nxt;
    res_status_r <= res_status_nxt;
    res_rd_r     <= res_rd_nxt;
    out_status_r <= out_status_nxt;
    out_rd_r     <= out_rd_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = $signed(out_rd_r);
  assign out_count      = out_count_r;

  `OALE_ASSERT_SAME(a_len_in_range, 1'b1, len_r <= CAP_L, "list length above capacity")
  `OALE_ASSERT_NEXT(a_accept_busy, accept, state_r != oale_pkg::ST_IDLE, "accepted item not worked")
  `OALE_ASSERT_NEXT(a_emit_loads, load_out, out_valid_r && state_r == oale_pkg::ST_IDLE, "result not loaded")
  `OALE_ASSERT_SAME(a_rd_zero, out_valid_r && out_status_r != oale_pkg::STAT_OK, out_rd_r == '0, "read value set on error")

endmodule
